/* design/psc_pkg.sv */
// shared constants, types and arithmetic helpers for the sphere collision pipeline
package psc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_BITS = 32;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;
	localparam int K_W = 17;
	localparam int R_W = WORD_BITS - 1;
	localparam int SQ_W = 2 * WORD_BITS + 2;
	localparam int ROOT_W = WORD_BITS + 1;
	localparam int Q_W = FRAC_BITS + 1;
	localparam int REM_W = ROOT_W + FRAC_BITS;
	localparam int N_W = FRAC_BITS + 2;
	localparam int MA_W = WORD_BITS + 2;
	localparam int MB_W = (N_W > K_W + 1) ? N_W : K_W + 1;

	localparam logic [R_W-1:0] SPHERE_RADIUS_RST = R_W'(65536);
	localparam logic [K_W-1:0] TIME_STEP_RST = K_W'(1092);
	localparam logic [K_W-1:0] RESTITUTION_RST = K_W'(65536);

	typedef enum logic [2:0] {
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_CENTER_Z,
		REG_SPHERE_RADIUS,
		REG_TIME_STEP,
		REG_RESTITUTION
	} reg_idx_t;

	typedef logic signed [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic [2:0][WORD_BITS-1:0] pos;
		logic [2:0][WORD_BITS-1:0] vel;
		logic [2:0] dneg;
		logic [2:0][WORD_BITS-1:0] dmag;
		logic [WORD_BITS-1:0] rsum;
		logic contact;
		logic degen;
	} item_t;

	// a*b / 2^F truncated toward zero
	function automatic logic signed [MA_W-1:0] mulq(input logic signed [MA_W-1:0] a,
			input logic signed [MB_W-1:0] b);
		logic [MA_W-1:0] ua;
		logic [MB_W-1:0] ub;
		logic [MA_W+MB_W-1:0] p;
		logic [MA_W-1:0] r;
		ua = a[MA_W-1] ? MA_W'(-a) : MA_W'(a);
		ub = b[MB_W-1] ? MB_W'(-b) : MB_W'(b);
		p = (MA_W+MB_W)'(ua) * (MA_W+MB_W)'(ub);
		r = p[FRAC_BITS +: MA_W];
		mulq = (a[MA_W-1] ^ b[MB_W-1]) ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic [WORD_BITS-1:0] sat(input logic [MA_W:0] x);
		logic [MA_W:0] ext;
		ext = {{(MA_W+1-WORD_BITS){x[WORD_BITS-1]}}, x[WORD_BITS-1:0]};
		if (ext == x)
			sat = x[WORD_BITS-1:0];
		else if (x[MA_W])
			sat = {1'b1, {(WORD_BITS-1){1'b0}}};
		else
			sat = {1'b0, {(WORD_BITS-1){1'b1}}};
	endfunction

endpackage

/* design/psc_isqrt.sv */
// pipelined integer square root, one root bit per stage, with carried transaction
module psc_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [psc_pkg::SQ_W-1:0]     radicand,
	input  psc_pkg::item_t               in_item,
	output logic                         out_valid,
	output logic [psc_pkg::ROOT_W-1:0]   root,
	output psc_pkg::item_t               out_item
);
	import psc_pkg::*;

	logic              valid_sk [1:ROOT_W];
	logic [SQ_W-1:0]   rem_sk   [1:ROOT_W];
	logic [ROOT_W-1:0] root_sk  [1:ROOT_W];
	item_t             item_sk  [1:ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stg
		localparam int B = ROOT_W - 1 - k;
		logic              prv_valid;
		logic [SQ_W-1:0]   prv_rem;
		logic [ROOT_W-1:0] prv_root;
		item_t             prv_item;
		logic [SQ_W-1:0]   trial;
		logic              take;

		if (k == 0) begin : g_head
			assign prv_valid = in_valid;
			assign prv_rem = radicand;
			assign prv_root = '0;
			assign prv_item = in_item;
		end else begin : g_tail
			assign prv_valid = valid_sk[k];
			assign prv_rem = rem_sk[k];
			assign prv_root = root_sk[k];
			assign prv_item = item_sk[k];
		end

		assign trial = (SQ_W'(prv_root) << (B + 1)) | (SQ_W'(1) << (2 * B));
		assign take = prv_rem >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sk[k+1] <= 1'b0;
			end else if (en) begin
				valid_sk[k+1] <= prv_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[k+1] <= take ? prv_rem - trial : prv_rem;
				root_sk[k+1] <= take ? prv_root | (ROOT_W'(1) << B) : prv_root;
				item_sk[k+1] <= prv_item;
			end
		end
	end

	assign out_valid = valid_sk[ROOT_W];
	assign root = root_sk[ROOT_W];
	assign out_item = item_sk[ROOT_W];

endmodule

/* design/psc_norm.sv */
// pipelined restoring divider, three lanes, giving the unit normal magnitudes
module psc_norm (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  logic [psc_pkg::ROOT_W-1:0]         dis,
	input  psc_pkg::item_t                     in_item,
	output logic                               out_valid,
	output logic [2:0][psc_pkg::Q_W-1:0]       quot,
	output logic [psc_pkg::ROOT_W-1:0]         out_dis,
	output psc_pkg::item_t                     out_item
);
	import psc_pkg::*;

	logic                   valid_sk [1:Q_W];
	logic [2:0][REM_W-1:0]  rem_sk   [1:Q_W];
	logic [2:0][Q_W-1:0]    quot_sk  [1:Q_W];
	logic [ROOT_W-1:0]      dis_sk   [1:Q_W];
	item_t                  item_sk  [1:Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_stg
		localparam int B = Q_W - 1 - k;
		logic                  prv_valid;
		logic [2:0][REM_W-1:0] prv_rem;
		logic [2:0][Q_W-1:0]   prv_quot;
		logic [ROOT_W-1:0]     prv_dis;
		item_t                 prv_item;
		logic [REM_W-1:0]      trial;
		logic [2:0][REM_W-1:0] nxt_rem;
		logic [2:0][Q_W-1:0]   nxt_quot;

		if (k == 0) begin : g_head
			assign prv_valid = in_valid;
			assign prv_quot = '0;
			assign prv_dis = dis;
			assign prv_item = in_item;
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign prv_rem[i] = REM_W'(in_item.dmag[i]) << FRAC_BITS;
			end
		end else begin : g_tail
			assign prv_valid = valid_sk[k];
			assign prv_rem = rem_sk[k];
			assign prv_quot = quot_sk[k];
			assign prv_dis = dis_sk[k];
			assign prv_item = item_sk[k];
		end

		assign trial = REM_W'(prv_dis) << B;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				if (prv_rem[i] >= trial) begin
					nxt_rem[i] = prv_rem[i] - trial;
					nxt_quot[i] = prv_quot[i] | (Q_W'(1) << B);
				end else begin
					nxt_rem[i] = prv_rem[i];
					nxt_quot[i] = prv_quot[i];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sk[k+1] <= 1'b0;
			end else if (en) begin
				valid_sk[k+1] <= prv_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[k+1] <= nxt_rem;
				quot_sk[k+1] <= nxt_quot;
				dis_sk[k+1] <= prv_dis;
				item_sk[k+1] <= prv_item;
			end
		end
	end

	assign out_valid = valid_sk[Q_W];
	assign quot = quot_sk[Q_W];
	assign out_dis = dis_sk[Q_W];
	assign out_item = item_sk[Q_W];

endmodule

/* design/particle_sphere_collision_response_top.sv */
// top level of the particle versus static sphere collision response pipeline
//
// one particle transaction enters on the in channel (in_valid / in_stall) and one
// result transaction leaves on the out channel (out_valid / out_stall) for each.
// the sphere centre, radius, time step and restitution are written over the apb
// port only while no transaction is in flight, a rule that binds the user, as the
// block does not enforce it; pready is always high, reads return the register
// contents. from acceptance to out_valid a transaction passes the registers of
// difference, square and overlap test, the square root pipeline, the normal
// divider and the registers of products, sums and saturation.
// throughput is one transaction per cycle unless a stalled result holds the pipeline.
// reset clears every valid bit and loads the register defaults; no pass is needed.
// when the receiver stalls a waiting result, the whole pipeline holds, and one
// more input transaction is still taken into a skid register; in_stall rises
// the cycle after and falls once the pipeline moves again.
module particle_sphere_collision_response_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [psc_pkg::ADDR_W-1:0]            paddr,
	input  logic [psc_pkg::DATA_W-1:0]            pwdata,
	output logic [psc_pkg::DATA_W-1:0]            prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [psc_pkg::WORD_BITS-1:0]  pos_x,
	input  logic signed [psc_pkg::WORD_BITS-1:0]  pos_y,
	input  logic signed [psc_pkg::WORD_BITS-1:0]  pos_z,
	input  logic signed [psc_pkg::WORD_BITS-1:0]  vel_x,
	input  logic signed [psc_pkg::WORD_BITS-1:0]  vel_y,
	input  logic signed [psc_pkg::WORD_BITS-1:0]  vel_z,
	input  logic [psc_pkg::R_W-1:0]               particle_radius,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [psc_pkg::WORD_BITS-1:0]  out_pos_x,
	output logic signed [psc_pkg::WORD_BITS-1:0]  out_pos_y,
	output logic signed [psc_pkg::WORD_BITS-1:0]  out_pos_z,
	output logic signed [psc_pkg::WORD_BITS-1:0]  out_vel_x,
	output logic signed [psc_pkg::WORD_BITS-1:0]  out_vel_y,
	output logic signed [psc_pkg::WORD_BITS-1:0]  out_vel_z,
	output logic                                  contact,
	output logic                                  degenerate
);
	import psc_pkg::*;

	typedef struct packed {
		logic [2:0][WORD_BITS-1:0] pos;
		logic [2:0][WORD_BITS-1:0] vel;
		logic [R_W-1:0] prad;
	} in_t;

	// configuration registers
	word_t          center_x_q, center_y_q, center_z_q;
	logic [R_W-1:0] sphere_radius_q;
	logic [K_W-1:0] time_step_q, restitution_q;
	reg_idx_t       ridx;

	assign pready = 1'b1;
	assign ridx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			sphere_radius_q <= SPHERE_RADIUS_RST;
			time_step_q <= TIME_STEP_RST;
			restitution_q <= RESTITUTION_RST;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_CENTER_X: center_x_q <= WORD_BITS'(pwdata);
				REG_CENTER_Y: center_y_q <= WORD_BITS'(pwdata);
				REG_CENTER_Z: center_z_q <= WORD_BITS'(pwdata);
				REG_SPHERE_RADIUS: sphere_radius_q <= pwdata[R_W-1:0];
				REG_TIME_STEP: time_step_q <= pwdata[K_W-1:0];
				REG_RESTITUTION: restitution_q <= pwdata[K_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_CENTER_X: prdata = DATA_W'(center_x_q);
			REG_CENTER_Y: prdata = DATA_W'(center_y_q);
			REG_CENTER_Z: prdata = DATA_W'(center_z_q);
			REG_SPHERE_RADIUS: prdata = DATA_W'(sphere_radius_q);
			REG_TIME_STEP: prdata = DATA_W'(time_step_q);
			REG_RESTITUTION: prdata = DATA_W'(restitution_q);
			default: prdata = '0;
		endcase
	end

	// skid register and global advance
	logic en;
	logic skid_full_q;
	in_t  skid_q;
	in_t  in_bus;
	in_t  ent;
	logic ent_valid;
	logic valid_s10;

	assign en = !(valid_s10 && out_stall);
	assign in_stall = skid_full_q;
	assign in_bus = '{pos: {pos_z, pos_y, pos_x}, vel: {vel_z, vel_y, vel_x},
		prad: particle_radius};
	assign ent_valid = skid_full_q || in_valid;
	assign ent = skid_full_q ? skid_q : in_bus;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (en) begin
			skid_full_q <= 1'b0;
		end else if (in_valid && !skid_full_q) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && in_valid && !skid_full_q) begin
			skid_q <= in_bus;
		end
	end

	// stage 1: centre difference
	logic [2:0][WORD_BITS-1:0] cen;
	logic [2:0][WORD_BITS:0]   dif;
	logic [2:0][WORD_BITS:0]   dabs;
	item_t s1_next;

	assign cen = {center_z_q, center_y_q, center_x_q};

	always_comb begin
		s1_next = '0;
		s1_next.pos = ent.pos;
		s1_next.vel = ent.vel;
		s1_next.rsum = WORD_BITS'(sphere_radius_q) + WORD_BITS'(ent.prad);
		for (int i = 0; i < 3; i++) begin
			dif[i] = {ent.pos[i][WORD_BITS-1], ent.pos[i]} - {cen[i][WORD_BITS-1], cen[i]};
			dabs[i] = dif[i][WORD_BITS] ? ~dif[i] + 1'b1 : dif[i];
			s1_next.dneg[i] = dif[i][WORD_BITS];
			s1_next.dmag[i] = dabs[i][WORD_BITS-1:0];
		end
	end

	logic valid_s1, valid_s2, valid_s3;
	item_t item_s1, item_s2, item_s3;
	logic [2:0][2*WORD_BITS-1:0] sqr_s2;
	logic [2*WORD_BITS-1:0] rsq_s2;
	logic [SQ_W-1:0] sq_s3;
	logic [SQ_W-1:0] sq_sum;
	logic over;
	logic zero;
	item_t s3_next;

	assign sq_sum = SQ_W'(sqr_s2[0]) + SQ_W'(sqr_s2[1]) + SQ_W'(sqr_s2[2]);
	assign over = SQ_W'(rsq_s2) > sq_sum;
	assign zero = sq_sum == '0;

	always_comb begin
		s3_next = item_s2;
		s3_next.contact = over && !zero;
		s3_next.degen = over && zero;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= s1_next;
			item_s2 <= item_s1;
			for (int i = 0; i < 3; i++) begin
				sqr_s2[i] <= (2*WORD_BITS)'(item_s1.dmag[i]) * (2*WORD_BITS)'(item_s1.dmag[i]);
			end
			rsq_s2 <= (2*WORD_BITS)'(item_s1.rsum) * (2*WORD_BITS)'(item_s1.rsum);
			item_s3 <= s3_next;
			sq_s3 <= sq_sum;
		end
	end

	// square root and normal division
	logic rt_valid;
	logic [ROOT_W-1:0] rt_dis;
	item_t rt_item;
	logic nm_valid;
	logic [2:0][Q_W-1:0] nm_quot;
	logic [ROOT_W-1:0] nm_dis;
	item_t nm_item;

	psc_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s3),
		.radicand  (sq_s3),
		.in_item   (item_s3),
		.out_valid (rt_valid),
		.root      (rt_dis),
		.out_item  (rt_item)
	);

	psc_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (rt_valid),
		.dis       (rt_dis),
		.in_item   (rt_item),
		.out_valid (nm_valid),
		.quot      (nm_quot),
		.out_dis   (nm_dis),
		.out_item  (nm_item)
	);

	// response arithmetic
	logic valid_s4, valid_s5, valid_s6, valid_s7, valid_s8, valid_s9;
	item_t item_s4, item_s5, item_s6, item_s7, item_s8, item_s9;
	logic [2:0][N_W-1:0] n_s4, n_s5, n_s6, n_s7;
	logic [MA_W-1:0] pen_s4, pen_s5, pen_s6, pen_s7;
	logic [2:0][MA_W-1:0] tvn_s5;
	logic [MA_W-1:0] vn_s6;
	logic [2:0][MA_W-1:0] m_s7;
	logic [2:0][MA_W-1:0] vm_s8, a_s8, b_s8, e_s8;
	logic [2:0][MA_W-1:0] c_s9, back_s9, b_s9, e_s9;
	logic [2:0][MA_W-1:0] bk;
	logic [2:0][MA_W:0] np, nv;
	logic [2:0][WORD_BITS-1:0] opos_s10, ovel_s10;
	logic contact_s10, degen_s10;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bk[i] = a_s8[i] + {{(MA_W-1){1'b0}}, a_s8[i][MA_W-1]};
			np[i] = (MA_W+1)'($signed(item_s9.pos[i])) + (MA_W+1)'($signed(b_s9[i]))
				- (MA_W+1)'($signed(back_s9[i]));
			nv[i] = (MA_W+1)'($signed(c_s9[i])) - (MA_W+1)'($signed(e_s9[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s4 <= nm_item;
			for (int i = 0; i < 3; i++) begin
				n_s4[i] <= nm_item.dneg[i] ? N_W'(-N_W'(nm_quot[i])) : N_W'(nm_quot[i]);
			end
			pen_s4 <= MA_W'(nm_item.rsum) - MA_W'(nm_dis);

			item_s5 <= item_s4;
			n_s5 <= n_s4;
			pen_s5 <= pen_s4;
			for (int i = 0; i < 3; i++) begin
				tvn_s5[i] <= mulq(MA_W'($signed(item_s4.vel[i])), MB_W'($signed(n_s4[i])));
			end

			item_s6 <= item_s5;
			n_s6 <= n_s5;
			pen_s6 <= pen_s5;
			vn_s6 <= MA_W'($signed(tvn_s5[0]) + $signed(tvn_s5[1]) + $signed(tvn_s5[2]));

			item_s7 <= item_s6;
			n_s7 <= n_s6;
			pen_s7 <= pen_s6;
			for (int i = 0; i < 3; i++) begin
				m_s7[i] <= mulq($signed(vn_s6), MB_W'($signed(n_s6[i])));
			end

			item_s8 <= item_s7;
			for (int i = 0; i < 3; i++) begin
				vm_s8[i] <= MA_W'($signed(item_s7.vel[i])) - $signed(m_s7[i]);
				a_s8[i] <= mulq($signed(m_s7[i]), MB_W'(time_step_q));
				b_s8[i] <= mulq($signed(pen_s7), MB_W'($signed(n_s7[i])));
				e_s8[i] <= mulq($signed(m_s7[i]), MB_W'(restitution_q));
			end

			item_s9 <= item_s8;
			b_s9 <= b_s8;
			e_s9 <= e_s8;
			for (int i = 0; i < 3; i++) begin
				c_s9[i] <= mulq($signed(vm_s8[i]), MB_W'(restitution_q));
				back_s9[i] <= {bk[i][MA_W-1], bk[i][MA_W-1:1]};
			end

			contact_s10 <= item_s9.contact;
			degen_s10 <= item_s9.degen;
			for (int i = 0; i < 3; i++) begin
				opos_s10[i] <= item_s9.contact ? sat(np[i]) : item_s9.pos[i];
				ovel_s10[i] <= item_s9.contact ? sat(nv[i]) : item_s9.vel[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
			valid_s10 <= 1'b0;
		end else if (en) begin
			valid_s1 <= ent_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= nm_valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
			valid_s10 <= valid_s9;
		end
	end

	assign out_valid = valid_s10;
	assign out_pos_x = opos_s10[0];
	assign out_pos_y = opos_s10[1];
	assign out_pos_z = opos_s10[2];
	assign out_vel_x = ovel_s10[0];
	assign out_vel_y = ovel_s10[1];
	assign out_vel_z = ovel_s10[2];
	assign contact = contact_s10;
	assign degenerate = degen_s10;

endmodule

/* design/psc_checker.sv */
// port level assertions for the sphere collision top level, bound to it
module psc_props (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_stall,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic signed [psc_pkg::WORD_BITS-1:0]  out_pos_x,
	input logic signed [psc_pkg::WORD_BITS-1:0]  out_vel_x,
	input logic                                  contact,
	input logic                                  degenerate
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_pos_x) && $stable(out_vel_x))
		else $error("stalled result changed");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(contact && degenerate))
		else $error("contact and degenerate both set");

	a_skid: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> $past(out_valid && out_stall))
		else $error("input stalled without output backpressure");

endmodule

bind particle_sphere_collision_response_top psc_props u_psc_props (.*);

/* sim/psc_checker.sv */
// checker for the sphere collision pipeline: predicts each result and compares it
`timescale 1ns / 100ps

module psc_checker
	import psc_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ADDR_W-1:0]           paddr,
	input  logic [DATA_W-1:0]           pwdata,
	input  logic                        pready,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic signed [WORD_BITS-1:0] pos_x,
	input  logic signed [WORD_BITS-1:0] pos_y,
	input  logic signed [WORD_BITS-1:0] pos_z,
	input  logic signed [WORD_BITS-1:0] vel_x,
	input  logic signed [WORD_BITS-1:0] vel_y,
	input  logic signed [WORD_BITS-1:0] vel_z,
	input  logic [R_W-1:0]              particle_radius,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic signed [WORD_BITS-1:0] out_pos_x,
	input  logic signed [WORD_BITS-1:0] out_pos_y,
	input  logic signed [WORD_BITS-1:0] out_pos_z,
	input  logic signed [WORD_BITS-1:0] out_vel_x,
	input  logic signed [WORD_BITS-1:0] out_vel_y,
	input  logic signed [WORD_BITS-1:0] out_vel_z,
	input  logic                        contact,
	input  logic                        degenerate,
	output int                          fails,
	output int                          n_in,
	output int                          n_out,
	output int                          n_contact,
	output int                          n_degen
);

	typedef struct {
		logic [WORD_BITS-1:0] pos [3];
		logic [WORD_BITS-1:0] vel [3];
		logic                 contact;
		logic                 degen;
	} response_t;

	longint        cen [3];
	logic [R_W-1:0] sph_r;
	logic [K_W-1:0] tstep;
	logic [K_W-1:0] rest;
	response_t     expected_q [$];

	function automatic longint fxmul(input longint a, input longint b);
		logic [63:0] ua;
		logic [63:0] ub;
		logic [127:0] pr;
		longint r;
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		pr = 128'(ua) * 128'(ub);
		r = longint'(pr >> FRAC_BITS);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic logic [WORD_BITS-1:0] clip(input longint x);
		if (x > 64'sd2147483647)
			return 32'h7fffffff;
		if (x < -64'sd2147483648)
			return 32'h80000000;
		return x[WORD_BITS-1:0];
	endfunction

	function automatic response_t collide(input longint p [3], input longint v [3],
			input logic [R_W-1:0] rp);
		response_t res;
		longint d [3];
		longint n [3];
		longint vn, pen, m, back;
		logic [63:0] md, rsum, dis, c, q;
		logic [127:0] sq;
		int i, b;
		sq = '0;
		for (i = 0; i < 3; i++) begin
			d[i] = p[i] - cen[i];
			md = (d[i] < 0) ? -d[i] : d[i];
			sq = sq + 128'(md) * 128'(md);
			res.pos[i] = clip(p[i]);
			res.vel[i] = clip(v[i]);
		end
		res.contact = 1'b0;
		res.degen = 1'b0;
		rsum = 64'(sph_r) + 64'(rp);
		if (128'(rsum) * 128'(rsum) > sq) begin
			if (sq == 0) begin
				res.degen = 1'b1;
			end else begin
				dis = '0;
				for (b = 55; b >= 0; b--) begin
					c = dis | (64'd1 << b);
					if (128'(c) * 128'(c) <= sq)
						dis = c;
				end
				pen = longint'(rsum) - longint'(dis);
				vn = 0;
				for (i = 0; i < 3; i++) begin
					md = (d[i] < 0) ? -d[i] : d[i];
					q = 64'((128'(md) << FRAC_BITS) / 128'(dis));
					n[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
					vn += fxmul(v[i], n[i]);
				end
				for (i = 0; i < 3; i++) begin
					m = fxmul(vn, n[i]);
					back = fxmul(m, longint'(tstep)) / 2;
					res.pos[i] = clip(p[i] + fxmul(pen, n[i]) - back);
					res.vel[i] = clip(fxmul(v[i] - m, longint'(rest)) -
						fxmul(m, longint'(rest)));
				end
				res.contact = 1'b1;
			end
		end
		return res;
	endfunction

	task automatic cmp(input string name, input logic [WORD_BITS-1:0] e,
			input logic [WORD_BITS-1:0] a);
		if (e !== a) begin
			$error("%s mismatch: expected %h actual %h", name, e, a);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		longint p [3];
		longint v [3];
		response_t e;
		if (!arst_n) begin
			cen[0] = 0;
			cen[1] = 0;
			cen[2] = 0;
			sph_r = SPHERE_RADIUS_RST;
			tstep = TIME_STEP_RST;
			rest = RESTITUTION_RST;
			expected_q.delete();
			fails = 0;
			n_in = 0;
			n_out = 0;
			n_contact = 0;
			n_degen = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_CENTER_X: cen[0] = longint'($signed(pwdata));
					REG_CENTER_Y: cen[1] = longint'($signed(pwdata));
					REG_CENTER_Z: cen[2] = longint'($signed(pwdata));
					REG_SPHERE_RADIUS: sph_r = pwdata[R_W-1:0];
					REG_TIME_STEP: tstep = pwdata[K_W-1:0];
					REG_RESTITUTION: rest = pwdata[K_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				p[0] = pos_x;
				p[1] = pos_y;
				p[2] = pos_z;
				v[0] = vel_x;
				v[1] = vel_y;
				v[2] = vel_z;
				expected_q.insert(expected_q.size(), collide(p, v, particle_radius));
				n_in++;
			end
			if (out_valid && !out_stall) begin
				n_out++;
				if (expected_q.size() == 0) begin
					$error("result transaction with no expectation waiting");
					fails++;
				end else begin
					e = expected_q.pop_front();
					cmp("out_pos_x", e.pos[0], out_pos_x);
					cmp("out_pos_y", e.pos[1], out_pos_y);
					cmp("out_pos_z", e.pos[2], out_pos_z);
					cmp("out_vel_x", e.vel[0], out_vel_x);
					cmp("out_vel_y", e.vel[1], out_vel_y);
					cmp("out_vel_z", e.vel[2], out_vel_z);
					cmp("contact", 32'(e.contact), 32'(contact));
					cmp("degenerate", 32'(e.degen), 32'(degenerate));
					if (e.contact)
						n_contact++;
					if (e.degen)
						n_degen++;
				end
			end
		end
	end

endmodule

/* sim/tb.sv */
// testbench top for the sphere collision pipeline: stimulus, config writes, verdict
`timescale 1ns / 100ps

module tb;
	import psc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_stall;
	logic signed [WORD_BITS-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [WORD_BITS-1:0] vel_x = '0, vel_y = '0, vel_z = '0;
	logic [R_W-1:0] particle_radius = '0;
	logic out_valid, out_stall = 1'b0;
	logic signed [WORD_BITS-1:0] out_pos_x, out_pos_y, out_pos_z;
	logic signed [WORD_BITS-1:0] out_vel_x, out_vel_y, out_vel_z;
	logic contact, degenerate;
	int fails, n_in, n_out, n_contact, n_degen;

	bit hold_req = 0;
	bit calm = 0;
	bit done = 0;
	int idle_cycles = 0;
	longint cen [3];
	longint sph_r;

	always #5 clk = ~clk;

	particle_sphere_collision_response_top DUT (.*);

	psc_checker chk (.*);

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(input longint cx, input longint cy, input longint cz,
			input logic [DATA_W-1:0] r, input logic [DATA_W-1:0] ts,
			input logic [DATA_W-1:0] rs);
		in_valid <= 1'b0;
		wait (n_out >= n_in);
		repeat (70) @(negedge clk);
		write_reg({REG_CENTER_X, 2'b00}, cx[31:0]);
		write_reg({REG_CENTER_Y, 2'b00}, cy[31:0]);
		write_reg({REG_CENTER_Z, 2'b00}, cz[31:0]);
		write_reg({REG_SPHERE_RADIUS, 2'b00}, r);
		write_reg({REG_TIME_STEP, 2'b00}, ts);
		write_reg({REG_RESTITUTION, 2'b00}, rs);
		// addresses past the register file must be ignored
		write_reg(5'd24, $urandom);
		write_reg(5'd28, $urandom);
		cen[0] = longint'($signed(cx[31:0]));
		cen[1] = longint'($signed(cy[31:0]));
		cen[2] = longint'($signed(cz[31:0]));
		sph_r = longint'(r[R_W-1:0]);
	endtask

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (calm || k < 65)
			return 0;
		if (k < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	task automatic send(input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
			input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz,
			input logic [R_W-1:0] rp);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		vel_x <= vx;
		vel_y <= vy;
		vel_z <= vz;
		particle_radius <= rp;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rnd_vel();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2 * 1310720)) - 1310720);
			2: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
			default: return 32'($signed($urandom_range(0, 131072)) - 65536);
		endcase
	endfunction

	task automatic send_random();
		longint reach, off [3];
		logic [R_W-1:0] rp;
		logic [31:0] p [3];
		int mode, i, ax;
		rp = ($urandom_range(0, 9) == 0) ? R_W'($urandom) : R_W'($urandom_range(0, 262144));
		mode = $urandom_range(0, 99);
		reach = sph_r + longint'(rp);
		if (reach > 64'sd2000000000)
			reach = 64'sd2000000000;
		for (i = 0; i < 3; i++) begin
			off[i] = longint'($urandom_range(0, 32'(2 * reach))) - reach;
			if (mode >= 60 && mode < 70)
				off[i] = 0;
			p[i] = 32'(cen[i] + off[i]);
		end
		if (mode >= 70 && mode < 80) begin
			// exact touch along one axis, or one unit off it
			ax = $urandom_range(0, 2);
			for (i = 0; i < 3; i++)
				p[i] = 32'(cen[i]);
			p[ax] = 32'(cen[ax] + (($urandom_range(0, 1) == 1) ? reach : -reach) -
				longint'($urandom_range(0, 1)));
		end else if (mode >= 80) begin
			p[0] = $urandom;
			p[1] = $urandom;
			p[2] = $urandom;
		end
		if (mode >= 60 && mode < 70 && $urandom_range(0, 3) == 0)
			rp = '0;
		send(p[0], p[1], p[2], rnd_vel(), rnd_vel(), rnd_vel(), rp);
	endtask

	// receiver: random stalls, plus one long hold-off when asked
	always @(negedge clk) begin
		int left;
		if (hold_req) begin
			out_stall <= 1'b1;
			repeat (400) @(negedge clk);
			hold_req = 0;
			left = 0;
		end else if (calm || done) begin
			out_stall <= 1'b0;
		end else if (left > 0) begin
			left--;
		end else begin
			out_stall <= ($urandom_range(0, 2) == 0);
			left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 3);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 20000) begin
			$display("timeout waiting on a transaction");
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int ph, k;
		cen[0] = 0;
		cen[1] = 0;
		cen[2] = 0;
		sph_r = 65536;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed items at the reset configuration
		send(32'h00008000, 0, 0, 32'hffff0000, 32'h00010000, 0, 0);
		send(32'h00020000, 0, 0, 32'h00010000, 0, 0, 31'h10000);
		send(32'h0001ffff, 0, 0, 32'hfff00000, 0, 0, 31'h10000);
		send(0, 0, 0, 32'h12345678, 0, 0, 31'h100);
		send(0, 0, 0, 0, 0, 0, 0);
		send(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 31'h7fffffff);
		send(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 31'h7fffffff);
		send(32'h80000000, 32'h7fffffff, 0, 32'h80000000, 32'h7fffffff, 0, 0);
		send(32'h00004000, 32'h00004000, 32'hffffc000, 32'h80000000, 32'h7fffffff,
			32'h80000000, 0);
		send(32'h00000001, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
		send(32'h00100000, 32'h00100000, 32'h00100000, 32'h00010000, 0, 0, 31'h100);
		send(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h00050000, 32'hfffb0000,
			32'h00050000, 0);

		for (ph = 0; ph < 7; ph++) begin
			case (ph)
				0: ;
				1: configure(64'sd1000000, -64'sd2500000, 64'sd300000, 32'h00030000,
					32'd3277, 32'd52428);
				2: configure(0, 0, 0, 32'h0, 32'h0, 32'h0);
				3: configure(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
					32'h7fffffff, 32'h00010000, 32'h00010000);
				4: configure(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
					32'hffffffff, 32'hfffe0000 | 32'd1092, 32'hfffe0000 | 32'd40000);
				5: configure(longint'($signed($urandom)), longint'($signed($urandom)),
					longint'($signed($urandom)), $urandom_range(1, 32'h01000000),
					$urandom_range(0, 65536), $urandom_range(0, 65536));
				default: configure(-64'sd70000, 64'sd12345, 0, 32'h00008000,
					32'h00010000, 32'h0);
			endcase
			calm = (ph == 6);
			if (ph == 1)
				hold_req = 1;
			if (ph == 2) begin
				// zero distance: no overlap with zero radii, degenerate with a particle radius of one
				send(0, 0, 0, 32'h00010000, 0, 0, 0);
				send(0, 0, 0, 0, 32'h00010000, 0, 31'h1);
			end
			for (k = 0; k < 155; k++)
				send_random();
		end
		in_valid <= 1'b0;

		wait (n_out >= n_in);
		done = 1;
		repeat (100) @(posedge clk);
		$display("%0d particles checked over seven sphere settings, %0d contacts,", n_out,
			n_contact);
		$display("%0d zero-distance cases, with random stalls and one long output hold-off",
			n_degen);
		if (fails == 0 && n_out == n_in)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* sim.f */
design/psc_pkg.sv
design/psc_isqrt.sv
design/psc_norm.sv
design/particle_sphere_collision_response_top.sv
design/psc_checker.sv
sim/psc_checker.sv
sim/tb.sv
